>>> rtl/gcd_pkg.sv
`default_nettype none
package gcd_pkg;

  // Coordinate format and iteration counts
  localparam int COORD_FRAC_BITS   = 16;
  localparam int CORDIC_ITERATIONS = 20;
  localparam int ROT_N = (CORDIC_ITERATIONS < 32) ? CORDIC_ITERATIONS : 32;

  // Field widths
  localparam int LAT_W  = 24;
  localparam int LON_W  = 25;
  localparam int DIST_W = 23;
  localparam int DLAT_W = LAT_W + 1;
  localparam int DLON_W = LON_W + 1;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Degree to phase conversion (phase in 2^-32 turn)
  localparam int PH_SHIFT = COORD_FRAC_BITS + 8;
  localparam int PH_W     = 32;
  localparam int PR_W     = PH_SHIFT + PH_W;
  localparam logic [31:0] DEG_TO_TURN = 32'd3054198966;
  localparam logic signed [PR_W-1:0] DEG_TO_TURN_S = $signed(PR_W'(DEG_TO_TURN));

  // Planar sum of squares
  localparam int PLAN_SHIFT = 2 * COORD_FRAC_BITS - 16;
  localparam int SUM_W      = 2 * DLON_W + 1;
  localparam int PLAN_W     = 51 - PLAN_SHIFT;

  // Datapath widths
  localparam int Q_FRAC  = 30;
  localparam int ROT_W   = 33;
  localparam int ANG_W   = 32;
  localparam int VEC_W   = 34;
  localparam int SQ_W    = 62;
  localparam int SQ_N    = 31;
  localparam int SQ_IW   = 5;
  localparam int ROOT_W  = 31;
  localparam int TURN_IW = 5;
  localparam longint Q30_ONE = 64'd1 << Q_FRAC;
  localparam logic signed [ROT_W-1:0] GAIN_Q30 = 33'sd652032874;
  localparam logic signed [ROT_W-1:0] ONE_ROT  = $signed(ROT_W'(Q30_ONE));

  // Angle to kilometres
  localparam int KM_W     = 34;
  localparam int KM_SHIFT = 40;
  localparam int MUL_W    = ROOT_W + KM_W;
  localparam logic [KM_W-1:0] KM_SCALE = 34'd5252682116;

  // Quadrant codes from the top phase bits
  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;

  // Rotation lanes
  localparam int N_LANE   = 4;
  localparam int LN_LAT_A = 0;
  localparam int LN_LAT_B = 1;
  localparam int LN_DLAT  = 2;
  localparam int LN_DLON  = 3;

  // Square root lanes
  localparam int SL_COS = 0;
  localparam int SL_SIN = 1;

  // Pipeline stage positions
  localparam int ST_IN   = 0;
  localparam int ST_PH   = 1;
  localparam int ST_ROT0 = 2;
  localparam int ST_PLN  = ST_ROT0 + 1;
  localparam int ST_Q    = ST_ROT0 + ROT_N;
  localparam int ST_H1   = ST_Q + 1;
  localparam int ST_H2   = ST_H1 + 1;
  localparam int ST_H3   = ST_H2 + 1;
  localparam int ST_SQ0  = ST_H3 + 1;
  localparam int ST_V0   = ST_SQ0 + SQ_N;
  localparam int ST_M    = ST_V0 + ROT_N;
  localparam int ST_OUT  = ST_M + 1;
  localparam int N_STG   = ST_OUT + 1;

  typedef struct packed {
    logic mode;
    logic unreach;
  } side_t;

  localparam logic [ANG_W-1:0] ATAN_TURNS [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  function automatic logic [ANG_W-1:0] atan_at(input logic [TURN_IW-1:0] i);
    return ATAN_TURNS[i];
  endfunction

endpackage
`default_nettype wire

>>> rtl/gcd_cfg_if.sv
`default_nettype none
interface gcd_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/gcd_in_if.sv
`default_nettype none
interface gcd_in_if import gcd_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [LAT_W-1:0] lat_a;
  logic signed [LON_W-1:0] lon_a;
  logic signed [LAT_W-1:0] lat_b;
  logic signed [LON_W-1:0] lon_b;
  logic a_present;
  logic b_present;
  modport source (output valid, output lat_a, output lon_a, output lat_b, output lon_b,
                  output a_present, output b_present, input ready);
  modport sink (input valid, input lat_a, input lon_a, input lat_b, input lon_b,
                input a_present, input b_present, output ready);
endinterface
`default_nettype wire

>>> rtl/gcd_out_if.sv
`default_nettype none
interface gcd_out_if import gcd_pkg::*; ();
  logic valid;
  logic ready;
  logic [DIST_W-1:0] distance;
  logic unreachable;
  modport source (output valid, output distance, output unreachable, input ready);
  modport sink (input valid, input distance, input unreachable, output ready);
endinterface
`default_nettype wire

>>> rtl/gcd_rot_cell.sv
`default_nettype none
module gcd_rot_cell import gcd_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic [TURN_IW-1:0]      idx,
  input  logic signed [ROT_W-1:0] x_in,
  input  logic signed [ROT_W-1:0] y_in,
  input  logic signed [ANG_W-1:0] z_in,
  input  logic [1:0]              q_in,
  output logic signed [ROT_W-1:0] x,
  output logic signed [ROT_W-1:0] y,
  output logic signed [ANG_W-1:0] z,
  output logic [1:0]              q
);
  logic signed [ROT_W-1:0] dx;
  logic signed [ROT_W-1:0] dy;
  logic signed [ANG_W-1:0] at;

  assign dx = y_in >>> idx;
  assign dy = x_in >>> idx;
  assign at = $signed(atan_at(idx));

  // Rotate toward zero residual angle
  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_in[ANG_W-1]) begin
        x <= x_in - dx;
        y <= y_in + dy;
        z <= z_in - at;
      end else begin
        x <= x_in + dx;
        y <= y_in - dy;
        z <= z_in + at;
      end
      q <= q_in;
    end
  end
endmodule
`default_nettype wire

>>> rtl/gcd_sqrt_cell.sv
`default_nettype none
module gcd_sqrt_cell import gcd_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [SQ_IW-1:0] k,
  input  logic [SQ_W-1:0]  v_in,
  input  logic [SQ_W-1:0]  r_in,
  output logic [SQ_W-1:0]  v,
  output logic [SQ_W-1:0]  r
);
  logic [SQ_W-1:0] bitv;
  logic [SQ_W-1:0] trial;

  assign bitv  = SQ_W'(1) << {k, 1'b0};
  assign trial = r_in + bitv;

  // Settle one root bit
  always_ff @(posedge clk) begin
    if (en) begin
      if (v_in >= trial) begin
        v <= v_in - trial;
        r <= (r_in >> 1) + bitv;
      end else begin
        v <= v_in;
        r <= r_in >> 1;
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/gcd_vec_cell.sv
`default_nettype none
module gcd_vec_cell import gcd_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic [TURN_IW-1:0]      idx,
  input  logic signed [VEC_W-1:0] x_in,
  input  logic signed [VEC_W-1:0] y_in,
  input  logic signed [ANG_W-1:0] z_in,
  output logic signed [VEC_W-1:0] x,
  output logic signed [VEC_W-1:0] y,
  output logic signed [ANG_W-1:0] z
);
  logic signed [VEC_W-1:0] dx;
  logic signed [VEC_W-1:0] dy;
  logic signed [ANG_W-1:0] at;

  assign dx = y_in >>> idx;
  assign dy = x_in >>> idx;
  assign at = $signed(atan_at(idx));

  // Drive y toward zero and accumulate the angle
  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[VEC_W-1]) begin
        x <= x_in + dx;
        y <= y_in - dy;
        z <= z_in + at;
      end else begin
        x <= x_in - dx;
        y <= y_in + dy;
        z <= z_in - at;
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/great_circle_distance.sv
// Throughput: one item per cycle; the whole cell chain advances together and
// holds only while a finished result waits at the output.
// Stages: input register, phase multiply, rotation cells, haversine products,
// 31 root cells per lane, vectoring cells, scale multiply, output register.
// Reset (rst, synchronous): clears all stage valid bits; mode returns to 1 (spherical).
`default_nettype none
module great_circle_distance import gcd_pkg::*; (
  input logic        clk,
  input logic        rst,
  gcd_cfg_if.sink    cfg,
  gcd_in_if.sink     req,
  gcd_out_if.source  rsp
);
  logic  mode;
  logic  adv;
  logic  vld  [N_STG];
  side_t side [N_STG];

  // Configuration register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      mode <= cfg.data;
    end
  end

  // Advance the chain unless the output item is stalled
  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < N_STG; s++) vld[s] <= 1'b0;
    end else if (adv) begin
      vld[ST_IN] <= req.valid;
      for (int s = 1; s < N_STG; s++) vld[s] <= vld[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[ST_IN].mode    <= mode;
      side[ST_IN].unreach <= !(req.a_present && req.b_present);
      for (int s = 1; s < N_STG; s++) side[s] <= side[s-1];
    end
  end

  // Input register
  logic signed [LAT_W-1:0] la, lb;
  logic signed [LON_W-1:0] oa, ob;
  always_ff @(posedge clk) begin
    if (adv) begin
      la <= req.lat_a;
      oa <= req.lon_a;
      lb <= req.lat_b;
      ob <= req.lon_b;
    end
  end

  // Phase conversion and planar differences
  logic signed [PR_W-1:0]   cw [N_LANE];
  logic signed [PR_W-1:0]   pr [N_LANE];
  logic [PH_W-1:0]          ph [N_LANE];
  logic signed [DLAT_W-1:0] dl;
  logic signed [DLON_W-1:0] dn;

  always_comb begin
    cw[0] = PR_W'(la);
    cw[1] = PR_W'(lb);
    cw[2] = PR_W'(oa);
    cw[3] = PR_W'(ob);
    for (int l = 0; l < N_LANE; l++) pr[l] = cw[l] * DEG_TO_TURN_S;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < N_LANE; l++) ph[l] <= pr[l][PH_SHIFT +: PH_W];
      dl <= DLAT_W'(la) - DLAT_W'(lb);
      dn <= DLON_W'(oa) - DLON_W'(ob);
    end
  end

  // Planar squares, sum and hold until the root stage
  logic signed [2*DLAT_W-1:0] sql;
  logic signed [2*DLON_W-1:0] sqn;
  logic [SUM_W-1:0]           ssum;
  logic [PLAN_W-1:0]          plan [ST_PLN:ST_H2];

  assign ssum = SUM_W'($unsigned(sql)) + SUM_W'($unsigned(sqn));

  always_ff @(posedge clk) begin
    if (adv) begin
      sql <= dl * dl;
      sqn <= dn * dn;
      plan[ST_PLN] <= PLAN_W'(ssum >> PLAN_SHIFT);
      for (int s = ST_PLN + 1; s <= ST_H2; s++) plan[s] <= plan[s-1];
    end
  end

  // Rotation lane start values
  logic [PH_W-1:0] lp [N_LANE];
  always_comb begin
    lp[LN_LAT_A] = ph[0];
    lp[LN_LAT_B] = ph[1];
    lp[LN_DLAT]  = ph[0] - ph[1];
    lp[LN_DLON]  = ph[3] - ph[2];
  end

  logic signed [ROT_W-1:0] rx [N_LANE][ROT_N];
  logic signed [ROT_W-1:0] ry [N_LANE][ROT_N];
  logic signed [ANG_W-1:0] rz [N_LANE][ROT_N];
  logic [1:0]              rq [N_LANE][ROT_N];

  for (genvar l = 0; l < N_LANE; l++) begin : g_rlane
    for (genvar i = 0; i < ROT_N; i++) begin : g_rcell
      if (i == 0) begin : g_first
        gcd_rot_cell u_cell (
          .clk (clk), .en (adv), .idx (TURN_IW'(i)),
          .x_in (GAIN_Q30), .y_in ('0),
          .z_in ($signed({2'b00, lp[l][PH_W-3:0]})), .q_in (lp[l][PH_W-1:PH_W-2]),
          .x (rx[l][i]), .y (ry[l][i]), .z (rz[l][i]), .q (rq[l][i])
        );
      end else begin : g_next
        gcd_rot_cell u_cell (
          .clk (clk), .en (adv), .idx (TURN_IW'(i)),
          .x_in (rx[l][i-1]), .y_in (ry[l][i-1]),
          .z_in (rz[l][i-1]), .q_in (rq[l][i-1]),
          .x (rx[l][i]), .y (ry[l][i]), .z (rz[l][i]), .q (rq[l][i])
        );
      end
    end
  end

  // Quadrant fold and haversine terms
  logic signed [ROT_W-1:0] cs  [N_LANE];
  logic signed [ROT_W:0]   omc [N_LANE];
  always_comb begin
    for (int l = 0; l < N_LANE; l++) begin
      case (rq[l][ROT_N-1])
        QUAD_I:   cs[l] = rx[l][ROT_N-1];
        QUAD_II:  cs[l] = -ry[l][ROT_N-1];
        QUAD_III: cs[l] = -rx[l][ROT_N-1];
        default:  cs[l] = ry[l][ROT_N-1];
      endcase
      omc[l] = (ROT_W+1)'(ONE_ROT) - (ROT_W+1)'(cs[l]);
    end
  end

  logic signed [ROT_W-1:0] cos_a, cos_b, hav_lat, hav_lon;
  always_ff @(posedge clk) begin
    if (adv) begin
      cos_a   <= cs[LN_LAT_A];
      cos_b   <= cs[LN_LAT_B];
      hav_lat <= ROT_W'(omc[LN_DLAT] >>> 1);
      hav_lon <= ROT_W'(omc[LN_DLON] >>> 1);
    end
  end

  // Cosine product, then scale the longitude term
  logic signed [2*ROT_W-1:0] ccp, llp;
  logic signed [ROT_W-1:0]   cc, hl1, hlo1, p2, h12;
  assign ccp = cos_a * cos_b;
  assign llp = cc * hlo1;

  always_ff @(posedge clk) begin
    if (adv) begin
      cc   <= ROT_W'(ccp >>> Q_FRAC);
      hl1  <= hav_lat;
      hlo1 <= hav_lon;
      p2   <= ROT_W'(llp >>> Q_FRAC);
      h12  <= hl1;
    end
  end

  // Clamp h and load the root lanes
  logic signed [ROT_W:0] hs;
  logic [ROOT_W-1:0]     hc;
  logic [SQ_W-1:0]       vx, vy;
  always_comb begin
    hs = (ROT_W+1)'(h12) + (ROT_W+1)'(p2);
    if (hs[ROT_W]) begin
      hc = '0;
    end else if (hs > (ROT_W+1)'(ONE_ROT)) begin
      hc = ROOT_W'(Q30_ONE);
    end else begin
      hc = ROOT_W'(hs);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vx <= SQ_W'(ROOT_W'(Q30_ONE) - hc) << Q_FRAC;
      vy <= side[ST_H2].mode ? (SQ_W'(hc) << Q_FRAC) : SQ_W'(plan[ST_H2]);
    end
  end

  // Root cells, two lanes
  logic [SQ_W-1:0] sv [2][SQ_N];
  logic [SQ_W-1:0] sr [2][SQ_N];
  logic [SQ_W-1:0] sv0 [2];
  assign sv0[SL_COS] = vx;
  assign sv0[SL_SIN] = vy;

  for (genvar l = 0; l < 2; l++) begin : g_slane
    for (genvar j = 0; j < SQ_N; j++) begin : g_scell
      if (j == 0) begin : g_first
        gcd_sqrt_cell u_cell (
          .clk (clk), .en (adv), .k (SQ_IW'(SQ_N - 1 - j)),
          .v_in (sv0[l]), .r_in ('0), .v (sv[l][j]), .r (sr[l][j])
        );
      end else begin : g_next
        gcd_sqrt_cell u_cell (
          .clk (clk), .en (adv), .k (SQ_IW'(SQ_N - 1 - j)),
          .v_in (sv[l][j-1]), .r_in (sr[l][j-1]), .v (sv[l][j]), .r (sr[l][j])
        );
      end
    end
  end

  // Vectoring cells recover the central angle
  logic signed [VEC_W-1:0] vcx [ROT_N];
  logic signed [VEC_W-1:0] vcy [ROT_N];
  logic signed [ANG_W-1:0] vcz [ROT_N];

  for (genvar i = 0; i < ROT_N; i++) begin : g_vcell
    if (i == 0) begin : g_first
      gcd_vec_cell u_cell (
        .clk (clk), .en (adv), .idx (TURN_IW'(i)),
        .x_in ($signed(VEC_W'(sr[SL_COS][SQ_N-1]))),
        .y_in ($signed(VEC_W'(sr[SL_SIN][SQ_N-1]))),
        .z_in ('0), .x (vcx[i]), .y (vcy[i]), .z (vcz[i])
      );
    end else begin : g_next
      gcd_vec_cell u_cell (
        .clk (clk), .en (adv), .idx (TURN_IW'(i)),
        .x_in (vcx[i-1]), .y_in (vcy[i-1]), .z_in (vcz[i-1]),
        .x (vcx[i]), .y (vcy[i]), .z (vcz[i])
      );
    end
  end

  // Hold the planar root alongside the vectoring cells
  logic [ROOT_W-1:0] proot [ST_V0:ST_M-1];
  always_ff @(posedge clk) begin
    if (adv) begin
      proot[ST_V0] <= ROOT_W'(sr[SL_SIN][SQ_N-1]);
      for (int s = ST_V0 + 1; s < ST_M; s++) proot[s] <= proot[s-1];
    end
  end

  // Clamp the angle and scale to kilometres
  logic [ROOT_W-1:0] zc;
  logic [MUL_W-1:0]  kmp;
  logic [ROOT_W-1:0] mval;
  always_comb begin
    if (vcz[ROT_N-1][ANG_W-1]) begin
      zc = '0;
    end else if (vcz[ROT_N-1] > $signed(ANG_W'(Q30_ONE))) begin
      zc = ROOT_W'(Q30_ONE);
    end else begin
      zc = ROOT_W'(vcz[ROT_N-1]);
    end
    kmp = MUL_W'(zc) * MUL_W'(KM_SCALE);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mval <= side[ST_M-1].mode ? ROOT_W'(kmp >> KM_SHIFT) : proot[ST_M-1];
    end
  end

  // Output register with saturation
  logic [DIST_W-1:0] out_dist;
  logic              unr;
  always_ff @(posedge clk) begin
    if (adv) begin
      unr <= side[ST_M].unreach;
      if (side[ST_M].unreach) begin
        out_dist <= '0;
      end else if (mval > ROOT_W'(DIST_MAX)) begin
        out_dist <= DIST_MAX;
      end else begin
        out_dist <= DIST_W'(mval);
      end
    end
  end

  assign rsp.valid       = vld[ST_OUT];
  assign rsp.distance    = out_dist;
  assign rsp.unreachable = unr;

`ifndef SYNTH
  a_unreach_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.unreachable |-> rsp.distance == '0)
    else $error("unreachable item carries a nonzero distance");

  a_root_split: assert property (@(posedge clk) disable iff (rst)
    vld[ST_H3] && side[ST_H3].mode |-> vx + vy == (SQ_W'(Q30_ONE) << Q_FRAC))
    else $error("root lane inputs do not sum to one");

  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    vld[ST_V0-1] && side[ST_V0-1].mode |->
      sr[SL_COS][SQ_N-1] <= SQ_W'(Q30_ONE) && sr[SL_SIN][SQ_N-1] <= SQ_W'(Q30_ONE))
    else $error("root exceeds one");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp.valid)
    else $error("output valid right after reset");
`endif

endmodule
`default_nettype wire

>>> tb/gcd_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module gcd_checker import gcd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  gcd_cfg_if    cfg,
  gcd_in_if     req,
  gcd_out_if    rsp,
  output int    errors,
  output int    pending
);

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              unreachable;
  } dist_result_t;

  localparam longint ONE_Q30   = 64'sd1 << 30;
  localparam longint COS_GAIN  = 64'sd652032874;
  localparam longint TURN_MUL  = 64'sd3054198966;
  localparam longint unsigned KM_MUL = 64'd5252682116;
  localparam longint unsigned SAT_DIST = 64'd8388607;

  localparam longint ANGLE_STEP [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0
  };

  logic         sphere_mode;
  dist_result_t dist_expect_q[$];

  assign pending = dist_expect_q.size();

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] deg_phase(input longint c);
    longint p;
    p = (c * TURN_MUL) >>> PH_SHIFT;
    return p[31:0];
  endfunction

  function automatic longint rot_cos(input logic [31:0] ph);
    longint x, y, z, dx, dy;
    x = COS_GAIN;
    y = 0;
    z = longint'(ph[29:0]);
    for (int i = 0; i < ROT_N; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ANGLE_STEP[i];
      end else begin
        x += dx; y -= dy; z += ANGLE_STEP[i];
      end
    end
    case (ph[31:30])
      2'd0: return x;
      2'd1: return -y;
      2'd2: return -x;
      default: return y;
    endcase
  endfunction

  function automatic longint half_versine(input logic [31:0] ph);
    return (ONE_Q30 - rot_cos(ph)) >>> 1;
  endfunction

  function automatic longint unsigned sphere_km(input longint la, oa, lb, ob);
    logic [31:0] pla, plb, poa, pob;
    longint h, cc, x, y, z, dx, dy;
    pla = deg_phase(la);
    plb = deg_phase(lb);
    poa = deg_phase(oa);
    pob = deg_phase(ob);
    cc = (rot_cos(pla) * rot_cos(plb)) >>> 30;
    h = half_versine(pla - plb) + ((cc * half_versine(pob - poa)) >>> 30);
    if (h < 0) h = 0;
    if (h > ONE_Q30) h = ONE_Q30;
    y = longint'(int_sqrt(longint'(h) << 30));
    x = longint'(int_sqrt(longint'(ONE_Q30 - h) << 30));
    z = 0;
    for (int i = 0; i < ROT_N; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ANGLE_STEP[i];
      end else begin
        x -= dx; y += dy; z -= ANGLE_STEP[i];
      end
    end
    if (z < 0) z = 0;
    if (z > ONE_Q30) z = ONE_Q30;
    return (longint'(z) * KM_MUL) >> 40;
  endfunction

  function automatic dist_result_t predict_distance(input logic signed [LAT_W-1:0] la,
      input logic signed [LON_W-1:0] oa, input logic signed [LAT_W-1:0] lb,
      input logic signed [LON_W-1:0] ob, input logic pa, input logic pb, input logic sph);
    dist_result_t res;
    longint dl, dn;
    longint unsigned d;
    res.distance = '0;
    res.unreachable = 1'b1;
    if (pa && pb) begin
      if (sph) begin
        d = sphere_km(longint'(la), longint'(oa), longint'(lb), longint'(ob));
      end else begin
        dl = longint'(la) - longint'(lb);
        dn = longint'(oa) - longint'(ob);
        d = int_sqrt((dl * dl + dn * dn) >> PLAN_SHIFT);
      end
      if (d > SAT_DIST) d = SAT_DIST;
      res.distance = d[DIST_W-1:0];
      res.unreachable = 1'b0;
    end
    return res;
  endfunction

  // Track the mode, predict on each input item, compare each result item
  always @(posedge clk) begin
    dist_result_t want;
    int           bad;
    bad = 0;
    if (rst) begin
      sphere_mode <= 1'b1;
      dist_expect_q.delete();
      errors <= 0;
    end else begin
      if (cfg.valid && cfg.ready) sphere_mode <= cfg.data;
      if (req.valid && req.ready)
        dist_expect_q.insert(dist_expect_q.size(), predict_distance(req.lat_a,
            req.lon_a, req.lat_b, req.lon_b, req.a_present, req.b_present,
            sphere_mode));
      if (rsp.valid && rsp.ready) begin
        if (dist_expect_q.size() == 0) begin
          $error("result item with nothing expected: distance %0d unreachable %0d",
                 rsp.distance, rsp.unreachable);
          bad = bad + 1;
        end else begin
          want = dist_expect_q.pop_front();
          if (want.distance !== rsp.distance) begin
            $error("distance: expected %0d, actual %0d", want.distance, rsp.distance);
            bad = bad + 1;
          end
          if (want.unreachable !== rsp.unreachable) begin
            $error("unreachable: expected %0d, actual %0d", want.unreachable,
                   rsp.unreachable);
            bad = bad + 1;
          end
        end
      end
      errors <= errors + bad;
    end
  end

endmodule
`default_nettype wire

>>> tb/great_circle_distance_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module great_circle_distance_tb;
  import gcd_pkg::*;

  localparam int LAT_MAX = 5898240;
  localparam int LON_MAX = 11796480;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 100;

  localparam logic signed [LAT_W-1:0] LAT_HI   = LAT_W'(LAT_MAX);
  localparam logic signed [LAT_W-1:0] LAT_LO   = LAT_W'(-LAT_MAX);
  localparam logic signed [LAT_W-1:0] LAT_ZERO = '0;
  localparam logic signed [LON_W-1:0] LON_HI   = LON_W'(LON_MAX);
  localparam logic signed [LON_W-1:0] LON_LO   = LON_W'(-LON_MAX);
  localparam logic signed [LON_W-1:0] LON_ZERO = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors, pending;
  int   cycles = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;

  gcd_cfg_if cfg ();
  gcd_in_if  req ();
  gcd_out_if rsp ();

  great_circle_distance DUT (.clk(clk), .rst(rst), .cfg(cfg), .req(req), .rsp(rsp));

  gcd_checker u_checker (.clk(clk), .rst(rst), .cfg(cfg), .req(req), .rsp(rsp),
                         .errors(errors), .pending(pending));

  always #5 clk = ~clk;

  // Stall the receiver at random
  always @(posedge clk) begin
    rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Abort on a hang
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** great_circle_distance: FAILED **");
      $finish;
    end
  end

  task automatic send_pair(input logic signed [LAT_W-1:0] la,
      input logic signed [LON_W-1:0] oa, input logic signed [LAT_W-1:0] lb,
      input logic signed [LON_W-1:0] ob, input logic pa, input logic pb);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.lat_a <= la;
    req.lon_a <= oa;
    req.lat_b <= lb;
    req.lon_b <= ob;
    req.a_present <= pa;
    req.b_present <= pb;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic drain_results();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    drain_results();
    cfg.valid <= 1'b1;
    cfg.data <= m;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  function automatic logic signed [LAT_W-1:0] pick_lat();
    case ($urandom_range(9))
      0: return LAT_W'($urandom);
      1: return $urandom_range(1) ? LAT_W'(LAT_MAX) : LAT_W'(-LAT_MAX);
      default: return LAT_W'(int'($urandom_range(2 * LAT_MAX)) - LAT_MAX);
    endcase
  endfunction

  function automatic logic signed [LON_W-1:0] pick_lon();
    case ($urandom_range(9))
      0: return LON_W'($urandom);
      1: return $urandom_range(1) ? LON_W'(LON_MAX) : LON_W'(-LON_MAX);
      default: return LON_W'(int'($urandom_range(2 * LON_MAX)) - LON_MAX);
    endcase
  endfunction

  task automatic directed_pairs();
    send_pair(LAT_ZERO, LON_ZERO, LAT_ZERO, LON_ZERO, 1'b1, 1'b1);
    send_pair(LAT_HI, LON_ZERO, LAT_LO, LON_ZERO, 1'b1, 1'b1);
    send_pair(LAT_HI, LON_HI, LAT_HI, LON_LO, 1'b1, 1'b1);
    send_pair(LAT_ZERO, LON_ZERO, LAT_ZERO, LON_HI, 1'b1, 1'b1);
    send_pair(LAT_ZERO, LON_LO, LAT_ZERO, LON_HI, 1'b1, 1'b1);
    send_pair(LAT_LO, LON_LO, LAT_HI, LON_HI, 1'b1, 1'b1);
    send_pair(LAT_W'(1), LON_W'(1), LAT_ZERO, LON_ZERO, 1'b1, 1'b1);
    send_pair(LAT_W'(3342336), LON_W'(-81920), LAT_W'(2670592),
              LON_W'(16384000 - LON_MAX), 1'b1, 1'b1);
    send_pair(LAT_W'(100), LON_W'(200), LAT_W'(300), LON_W'(400), 1'b0, 1'b1);
    send_pair(LAT_W'(100), LON_W'(200), LAT_W'(300), LON_W'(400), 1'b1, 1'b0);
    send_pair(LAT_ZERO, LON_ZERO, LAT_ZERO, LON_ZERO, 1'b0, 1'b0);
    // out-of-range bit patterns are used as given
    send_pair({1'b0, {(LAT_W-1){1'b1}}}, {1'b0, {(LON_W-1){1'b1}}},
              {1'b1, {(LAT_W-1){1'b0}}}, {1'b1, {(LON_W-1){1'b0}}}, 1'b1, 1'b1);
    send_pair('1, '1, {1'b0, {(LAT_W-1){1'b1}}}, {1'b0, {(LON_W-1){1'b1}}}, 1'b1, 1'b1);
    send_pair({1'b1, {(LAT_W-1){1'b0}}}, '1, '1, {1'b1, {(LON_W-1){1'b0}}}, 1'b1, 1'b1);
  endtask

  task automatic random_pairs(input int count);
    logic signed [LAT_W-1:0] la, lb;
    logic signed [LON_W-1:0] oa, ob;
    for (int k = 0; k < count; k++) begin
      la = pick_lat();
      oa = pick_lon();
      if ($urandom_range(3) == 0) begin
        // nearby second point
        lb = la + LAT_W'(int'($urandom_range(2000)) - 1000);
        ob = oa + LON_W'(int'($urandom_range(2000)) - 1000);
      end else begin
        lb = pick_lat();
        ob = pick_lon();
      end
      send_pair(la, oa, lb, ob, $urandom_range(9) != 0, $urandom_range(9) != 0);
    end
  endtask

  initial begin
    cfg.valid = 1'b0;
    cfg.data = 1'b0;
    req.valid = 1'b0;
    req.lat_a = '0;
    req.lon_a = '0;
    req.lat_b = '0;
    req.lon_b = '0;
    req.a_present = 1'b0;
    req.b_present = 1'b0;
    rsp.ready = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pairs in reset mode, then planar
    directed_pairs();
    write_mode(1'b0);
    directed_pairs();

    // Random phases over the idling patterns, in both modes
    send_idle_pct = 0;  recv_stall_pct = 0;
    random_pairs(150);
    write_mode(1'b1);
    send_idle_pct = 72; recv_stall_pct = 0;
    random_pairs(150);
    // hold the sender until every result is back
    drain_results();
    send_idle_pct = 0;  recv_stall_pct = 72;
    random_pairs(150);
    write_mode(1'b0);
    send_idle_pct = 31; recv_stall_pct = 31;
    random_pairs(80);
    write_mode(1'b1);
    random_pairs(70);

    drain_results();
    if (errors == 0) begin
      $display("** great_circle_distance: PASSED **");
    end else begin
      $display("** great_circle_distance: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
